// ===== design/npcm_pkg.sv =====
`default_nettype none

package npcm_pkg;

	// Palette depth and fixed-point precision of the XYZ coefficients.
	localparam int PALETTE_DEPTH  = 256;
	localparam int COEF_FRAC_BITS = 16;

	// A load item can address 256 slots, so the chain never needs more cells.
	localparam int NCELL = (PALETTE_DEPTH < 256) ? PALETTE_DEPTH : 256;

	// Field widths.
	localparam int CH_W   = 8;
	localparam int IDX_W  = 8;
	localparam int CODE_W = 8;
	localparam int CNT_W  = 9;
	localparam int DIST_W = 36;

	// Derived arithmetic widths. An XYZ component stays below 2^(COEF_FRAC_BITS+1).
	localparam int COEF_W = COEF_FRAC_BITS;
	localparam int ACC_W  = COEF_W + 10;
	localparam int XYZ_W  = COEF_FRAC_BITS + 1;
	localparam int SQ_W   = 2 * XYZ_W;
	localparam int SUM_W  = SQ_W + 2;

	// Input item as it arrives on the item channel.
	typedef struct packed {
		logic              mode;
		logic [IDX_W-1:0]  entry_index;
		logic [CODE_W-1:0] entry_code;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic [CH_W-1:0]   alpha;
	} item_t;

	// Result item as it leaves on the result channel.
	typedef struct packed {
		logic [CODE_W-1:0] color_code;
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] best_distance;
		logic              no_entries;
	} result_t;

	// Beat that travels down the cell chain: a load or a pixel with its running best.
	typedef struct packed {
		logic              load;
		logic              skip;
		logic              noent;
		logic [IDX_W-1:0]  idx;
		logic [CODE_W-1:0] code;
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic [XYZ_W-1:0]  cx;
		logic [XYZ_W-1:0]  cy;
		logic [XYZ_W-1:0]  cz;
		logic [SUM_W-1:0]  best_dist;
		logic [IDX_W-1:0]  best_idx;
		logic [CODE_W-1:0] best_code;
	} beat_t;

	// Palette entry held inside one cell.
	typedef struct packed {
		logic [CH_W-1:0]   red;
		logic [CH_W-1:0]   green;
		logic [CH_W-1:0]   blue;
		logic [CODE_W-1:0] code;
		logic [XYZ_W-1:0]  cx;
		logic [XYZ_W-1:0]  cy;
		logic [XYZ_W-1:0]  cz;
	} entry_t;

	// Coefficient in millionths rounded half up to COEF_FRAC_BITS fraction bits.
	function automatic logic [COEF_W-1:0] coef_fix(input longint unsigned micro);
		return COEF_W'(((micro << COEF_FRAC_BITS) + 64'd500000) / 64'd1000000);
	endfunction

	// RGB to XYZ matrix, row-major X, Y, Z.
	localparam logic [COEF_W-1:0] COEF [9] = '{
		coef_fix(64'd412453), coef_fix(64'd357580), coef_fix(64'd180423),
		coef_fix(64'd212671), coef_fix(64'd715160), coef_fix(64'd72169),
		coef_fix(64'd19334),  coef_fix(64'd119193), coef_fix(64'd950227)
	};

	// One XYZ component: weighted channel sum shifted right by 8.
	function automatic logic [XYZ_W-1:0] xyz_row(
		input logic [CH_W-1:0]   r,
		input logic [CH_W-1:0]   g,
		input logic [CH_W-1:0]   b,
		input logic [COEF_W-1:0] k0,
		input logic [COEF_W-1:0] k1,
		input logic [COEF_W-1:0] k2
	);
		logic [ACC_W-1:0] acc;
		acc = ACC_W'(k0) * ACC_W'(r) + ACC_W'(k1) * ACC_W'(g) + ACC_W'(k2) * ACC_W'(b);
		return XYZ_W'(acc >> 8);
	endfunction

endpackage

`default_nettype wire

// ===== design/npcm_xyz.sv =====
`default_nettype none

module npcm_xyz import npcm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic [CNT_W-1:0] palette_count,
	input  wire logic             item_valid,
	input  wire item_t            item,
	output logic                  beat_vld,
	output beat_t                 beat
);

	beat_t beat_d;
	logic  vld_q;
	beat_t beat_q;

	// Convert the color to XYZ and seed the running best for a pixel.
	always_comb begin
		beat_d           = '0;
		beat_d.load      = !item.mode;
		beat_d.skip      = item.mode && ((item.alpha == '0) || (palette_count == '0));
		beat_d.noent     = item.mode && (item.alpha != '0) && (palette_count == '0);
		beat_d.idx       = item.entry_index;
		beat_d.code      = item.entry_code;
		beat_d.red       = item.red;
		beat_d.green     = item.green;
		beat_d.blue      = item.blue;
		beat_d.cx        = xyz_row(item.red, item.green, item.blue, COEF[0], COEF[1], COEF[2]);
		beat_d.cy        = xyz_row(item.red, item.green, item.blue, COEF[3], COEF[4], COEF[5]);
		beat_d.cz        = xyz_row(item.red, item.green, item.blue, COEF[6], COEF[7], COEF[8]);
		beat_d.best_dist = '0;
		beat_d.best_idx  = '0;
		beat_d.best_code = '0;
	end

	// Beat valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= item_valid;
		end
	end

	// Beat payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			beat_q <= beat_d;
		end
	end

	assign beat_vld = vld_q;
	assign beat     = beat_q;

endmodule

`default_nettype wire

// ===== design/npcm_cell.sv =====
`default_nettype none

module npcm_cell import npcm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             advance,
	input  wire logic             color_space,
	input  wire logic [CNT_W-1:0] palette_count,
	input  wire logic [IDX_W-1:0] cell_idx,
	input  wire logic             in_vld,
	input  wire beat_t            in_beat,
	output logic                  out_vld,
	output beat_t                 out_beat
);

	entry_t            entry_q;
	logic              vld_s1;
	beat_t             beat_s1;
	logic [SQ_W-1:0]   sq_s1 [3];
	logic [CODE_W-1:0] code_s1;
	logic [XYZ_W-1:0]  pa [3];
	logic [XYZ_W-1:0]  pb [3];
	logic [XYZ_W-1:0]  dif [3];
	logic [SQ_W-1:0]   sq [3];
	logic [SUM_W-1:0]  sum;
	logic              in_range;
	logic              take;
	beat_t             beat_d;
	logic              vld_q;
	beat_t             beat_q;

	// A load beat whose slot matches this cell replaces the stored entry.
	always_ff @(posedge clk) begin
		if (advance && in_vld && in_beat.load && (in_beat.idx == cell_idx)) begin
			entry_q.red   <= in_beat.red;
			entry_q.green <= in_beat.green;
			entry_q.blue  <= in_beat.blue;
			entry_q.code  <= in_beat.code;
			entry_q.cx    <= in_beat.cx;
			entry_q.cy    <= in_beat.cy;
			entry_q.cz    <= in_beat.cz;
		end
	end

	// Pick the operands of the active space and square their differences.
	always_comb begin
		pa[0] = color_space ? in_beat.cx : XYZ_W'(in_beat.red);
		pa[1] = color_space ? in_beat.cy : XYZ_W'(in_beat.green);
		pa[2] = color_space ? in_beat.cz : XYZ_W'(in_beat.blue);
		pb[0] = color_space ? entry_q.cx : XYZ_W'(entry_q.red);
		pb[1] = color_space ? entry_q.cy : XYZ_W'(entry_q.green);
		pb[2] = color_space ? entry_q.cz : XYZ_W'(entry_q.blue);
		for (int k = 0; k < 3; k++) begin
			dif[k] = (pa[k] > pb[k]) ? (pa[k] - pb[k]) : (pb[k] - pa[k]);
			sq[k]  = SQ_W'(dif[k]) * SQ_W'(dif[k]);
		end
	end

	// First stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= in_vld;
		end
	end

	// First stage payload; the code is sampled with the colors it belongs to.
	always_ff @(posedge clk) begin
		if (advance) begin
			beat_s1 <= in_beat;
			sq_s1   <= sq;
			code_s1 <= entry_q.code;
		end
	end

	// Sum the squares and keep this entry if it is in range and either strictly nearer or the first cell.
	always_comb begin
		sum      = SUM_W'(sq_s1[0]) + SUM_W'(sq_s1[1]) + SUM_W'(sq_s1[2]);
		in_range = {1'b0, cell_idx} < palette_count;
		take     = !beat_s1.load && !beat_s1.skip && in_range &&
			((cell_idx == '0) || (sum < beat_s1.best_dist));
		beat_d   = beat_s1;
		if (take) begin
			beat_d.best_dist = sum;
			beat_d.best_idx  = cell_idx;
			beat_d.best_code = code_s1;
		end
	end

	// Hand-off register to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (advance) begin
			vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_q <= beat_d;
		end
	end

	assign out_vld  = vld_q;
	assign out_beat = beat_q;

endmodule

`default_nettype wire

// ===== design/nearest_palette_color_match_core.sv =====
`default_nettype none

// Nearest palette color match.
// Items arrive on the item channel (item, item_valid, item_stall). A load beat
// (mode 0) writes one palette slot and gives no result; a pixel beat (mode 1)
// gives one beat on the result channel (result, result_valid, result_stall)
// with the code, slot and squared distance of the nearest palette entry.
// The palette lives in a chain of NCELL cells, one entry per cell. Every beat,
// loads included, walks the chain in order, so a load affects exactly the
// pixels that follow it. Each cell squares the channel differences into its
// first stage register, then sums and compares into its hand-off register.
// One item is accepted every cycle unless a stalled result holds the chain.
// A stalled result holds the whole chain, and item_stall rises in the same
// cycle. Reset clears all valid flags and both registers; palette slots hold
// nothing defined until loaded. The user must write registers over the
// APB-style port only while no item is in flight; the block does not enforce
// it. Addresses: color_space at 0x0, palette_count at 0x4.
module nearest_palette_color_match_core import npcm_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire item_t       item,
	input  wire logic        item_valid,
	output logic             item_stall,
	output result_t          result,
	output logic             result_valid,
	input  wire logic        result_stall
);

	localparam logic REG_COLOR_SPACE   = 1'b0;
	localparam logic REG_PALETTE_COUNT = 1'b1;
	localparam int   CMP_W = (SUM_W > DIST_W) ? SUM_W : DIST_W;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	logic             color_space_q;
	logic [CNT_W-1:0] palette_count_q;
	logic             advance;
	logic             chain_vld [NCELL+1];
	beat_t            chain_beat [NCELL+1];
	beat_t            last_beat;
	logic [CMP_W-1:0] dist_ext;
	logic [DIST_W-1:0] dist_sat;
	logic             result_vld_q;
	result_t          result_q;

	// Register writes and reads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_space_q   <= 1'b0;
			palette_count_q <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_COLOR_SPACE:   color_space_q   <= pwdata[0];
				REG_PALETTE_COUNT: palette_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_COLOR_SPACE:   prdata = {31'b0, color_space_q};
			REG_PALETTE_COUNT: prdata = {{(32-CNT_W){1'b0}}, palette_count_q};
			default:           prdata = '0;
		endcase
	end

	assign pready = 1'b1;

	// The chain moves whenever the result register is free or being taken.
	assign advance    = !result_vld_q || !result_stall;
	assign item_stall = !advance;

	// Color conversion ahead of the chain.
	npcm_xyz u_xyz (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.palette_count (palette_count_q),
		.item_valid    (item_valid),
		.item          (item),
		.beat_vld      (chain_vld[0]),
		.beat          (chain_beat[0])
	);

	// Row of palette cells.
	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		npcm_cell u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.advance       (advance),
			.color_space   (color_space_q),
			.palette_count (palette_count_q),
			.cell_idx      (IDX_W'(i)),
			.in_vld        (chain_vld[i]),
			.in_beat       (chain_beat[i]),
			.out_vld       (chain_vld[i+1]),
			.out_beat      (chain_beat[i+1])
		);
	end

	// Saturate the winning distance to the result field.
	always_comb begin
		last_beat = chain_beat[NCELL];
		dist_ext  = CMP_W'(last_beat.best_dist);
		dist_sat  = (dist_ext > CMP_W'(DIST_MAX)) ? DIST_MAX : dist_ext[DIST_W-1:0];
	end

	// Result register; only pixel beats produce a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_vld_q <= 1'b0;
		end else if (advance) begin
			result_vld_q <= chain_vld[NCELL] && !last_beat.load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.color_code    <= last_beat.best_code;
			result_q.best_index    <= last_beat.best_idx;
			result_q.best_distance <= dist_sat;
			result_q.no_entries    <= last_beat.noent;
		end
	end

	assign result_valid = result_vld_q;
	assign result       = result_q;

	// An empty-palette result comes only from a zero count and carries no distance.
	a_noent: assert property (@(posedge clk) disable iff (!arst_n)
		result_vld_q && result_q.no_entries |->
			(palette_count_q == '0) && (result_q.best_distance == '0))
		else $error("empty-palette result with nonzero count or distance");

	// The winning slot always lies inside the searched range.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_vld_q && !result_q.no_entries && (palette_count_q != '0) |->
			({1'b0, result_q.best_index} < palette_count_q))
		else $error("best index outside the searched palette range");

	// Items are held back only while a finished result waits.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_vld_q && result_stall)
		else $error("item channel stalled without a waiting result");

endmodule

`default_nettype wire
